FILE: design/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared widths and codes of the range maximum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int SIZE       = 262144;
	localparam int IDX_W      = 19;
	localparam int VAL_W      = 31;
	localparam int NODE_W     = 20;
	localparam int MEM_DEPTH  = 1 << NODE_W;

	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 2;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [1:0] ST_UPD = 2'd0;
	localparam logic [1:0] ST_QRY = 2'd1;
	localparam logic [1:0] ST_ERR = 2'd2;

endpackage

FILE: design/range_max_segment_tree.sv
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Range maximum segment tree with point updates, node store in one RAM.
// ----------------------------------------------------------------------------
// channel   direction  beat
// s_axis    in         one request: update or range query
// m_axis    out        one result per request
// cfg       in         element_count write
//
// Update: descends level by level to the leaf, then climbs with a sibling
// read and a parent write per level.
// Query: at most one node read per level and path.
// Bad index or range: sent straight to the result. The RAM has one read port.
// s_axis_tready rises in the same cycle as m_axis_tvalid.
// After reset a clearing pass zeroes all 1048576 nodes, one per cycle,
// with s_axis_tready low. A waiting result does not block the next request
// until that request finishes.
// ----------------------------------------------------------------------------
module range_max_segment_tree (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [18:0] low_index, [37:19] high_index, [68:38] new_value
	input  logic [rmst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic [rmst_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [30:0] max_value
	output logic [rmst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] status
	output logic [rmst_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rmst_pkg::IDX_W-1:0]      cfg_data
);
	import rmst_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_UDESC  = 10'b00_0000_0100,
		S_UASCRD = 10'b00_0000_1000,
		S_UASCWR = 10'b00_0001_0000,
		S_QDESC  = 10'b00_0010_0000,
		S_QLEFT  = 10'b00_0100_0000,
		S_QRIGHT = 10'b00_1000_0000,
		S_QDRAIN = 10'b01_0000_0000,
		S_FINISH = 10'b10_0000_0000
	} state_t;

	localparam logic [IDX_W-1:0]  SIZE_C   = IDX_W'(SIZE);
	localparam logic [IDX_W-1:0]  ONE_IDX  = IDX_W'(1);
	localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);
	localparam logic [NODE_W-1:0] LAST_ADR = NODE_W'(MEM_DEPTH - 1);

	logic [VAL_W-1:0] mem [MEM_DEPTH];

	state_t              state_q;
	logic [IDX_W-1:0]    count_q;
	logic [NODE_W-1:0]   clr_q;
	logic [IDX_W-1:0]    lo_q, hi_q, l_q, r_q, sl_q, sr_q;
	logic [NODE_W-1:0]   node_q, sn_q;
	logic [VAL_W-1:0]    val_q, best_q, rd_data_q, res_val_q;
	logic [1:0]          res_st_q;
	logic                qrd_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    out_val_q;
	logic [1:0]          out_st_q;

	logic                in_req;
	logic [IDX_W-1:0]    in_lo, in_hi, n_eff;
	logic [VAL_W-1:0]    in_val;
	logic                in_ok;
	logic [IDX_W:0]      lr_sum;
	logic [IDX_W-1:0]    mid, mid_p1;
	logic [NODE_W-1:0]   child_l, child_r;
	logic [VAL_W-1:0]    fold, pmax;
	logic                rd_en, wr_en, qrd;
	logic [NODE_W-1:0]   rd_addr, wr_addr;
	logic [VAL_W-1:0]    wr_data;
	logic                out_free;

	assign in_req = s_axis_tuser[0];
	assign in_lo  = s_axis_tdata[IDX_W-1:0];
	assign in_hi  = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_val = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
	assign n_eff  = (count_q > SIZE_C) ? SIZE_C : count_q;

	always_comb begin
		if (in_req == REQ_UPDATE) begin
			in_ok = (in_lo >= ONE_IDX) && (in_lo <= n_eff);
		end else begin
			in_ok = (in_lo >= ONE_IDX) && (in_hi >= ONE_IDX) && (in_lo <= n_eff)
				&& (in_hi <= n_eff) && (in_lo <= in_hi);
		end
	end

	assign lr_sum  = {1'b0, l_q} + {1'b0, r_q};
	assign mid     = lr_sum[IDX_W:1];
	assign mid_p1  = mid + ONE_IDX;
	assign child_l = {node_q[NODE_W-2:0], 1'b0};
	assign child_r = {node_q[NODE_W-2:0], 1'b1};
	assign fold    = (rd_data_q > best_q) ? rd_data_q : best_q;
	assign pmax    = (rd_data_q > val_q) ? rd_data_q : val_q;
	assign out_free = !out_valid_q || m_axis_tready;

	// RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = node_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = val_q;
		qrd     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_UDESC: begin
				wr_en = (l_q == r_q);
			end
			S_UASCRD: begin
				rd_en   = 1'b1;
				rd_addr = {node_q[NODE_W-1:1], ~node_q[0]};
			end
			S_UASCWR: begin
				wr_en   = 1'b1;
				wr_addr = {1'b0, node_q[NODE_W-1:1]};
				wr_data = pmax;
			end
			S_QDESC: begin
				qrd = (lo_q <= l_q) && (r_q <= hi_q);
			end
			S_QLEFT: begin
				if (lo_q <= l_q) begin
					qrd = 1'b1;
				end else if (lo_q <= mid) begin
					qrd     = 1'b1;
					rd_addr = child_r;
				end
			end
			S_QRIGHT: begin
				if (r_q <= hi_q) begin
					qrd = 1'b1;
				end else if (hi_q > mid) begin
					qrd     = 1'b1;
					rd_addr = child_l;
				end
			end
			default: ;
		endcase
		if (qrd) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= SIZE_C;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			qrd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			qrd_q <= qrd;
			if (out_valid_q && m_axis_tready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ROOT;
					if (clr_q == LAST_ADR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						if (!in_ok) begin
							state_q <= S_FINISH;
						end else if (in_req == REQ_UPDATE) begin
							state_q <= S_UDESC;
						end else begin
							state_q <= S_QDESC;
						end
					end
				end
				S_UDESC: begin
					if (l_q == r_q) begin
						state_q <= (node_q == ROOT) ? S_FINISH : S_UASCRD;
					end
				end
				S_UASCRD: begin
					state_q <= S_UASCWR;
				end
				S_UASCWR: begin
					state_q <= (node_q[NODE_W-1:1] == ROOT[NODE_W-2:0]) ? S_FINISH : S_UASCRD;
				end
				S_QDESC: begin
					if ((lo_q <= l_q) && (r_q <= hi_q)) begin
						state_q <= S_QDRAIN;
					end else if ((hi_q > mid) && (lo_q <= mid)) begin
						state_q <= S_QLEFT;
					end
				end
				S_QLEFT: begin
					if (lo_q <= l_q) begin
						state_q <= S_QRIGHT;
					end
				end
				S_QRIGHT: begin
					if (r_q <= hi_q) begin
						state_q <= S_QDRAIN;
					end
				end
				S_QDRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (qrd_q) begin
			best_q <= fold;
		end
		case (state_q)
			S_IDLE: begin
				lo_q     <= in_lo;
				hi_q     <= in_hi;
				val_q    <= in_val;
				l_q      <= ONE_IDX;
				r_q      <= n_eff;
				node_q   <= ROOT;
				best_q   <= '0;
				res_val_q <= '0;
				res_st_q  <= !in_ok ? ST_ERR : (in_req == REQ_UPDATE) ? ST_UPD : ST_QRY;
			end
			S_UDESC: begin
				if (l_q != r_q) begin
					if (lo_q <= mid) begin
						r_q    <= mid;
						node_q <= child_l;
					end else begin
						l_q    <= mid_p1;
						node_q <= child_r;
					end
				end
			end
			S_UASCWR: begin
				val_q  <= pmax;
				node_q <= {1'b0, node_q[NODE_W-1:1]};
			end
			S_QDESC: begin
				if (!((lo_q <= l_q) && (r_q <= hi_q))) begin
					if (hi_q <= mid) begin
						r_q    <= mid;
						node_q <= child_l;
					end else if (lo_q > mid) begin
						l_q    <= mid_p1;
						node_q <= child_r;
					end else begin
						r_q    <= mid;
						node_q <= child_l;
						sl_q   <= mid_p1;
						sr_q   <= r_q;
						sn_q   <= child_r;
					end
				end
			end
			S_QLEFT: begin
				if (lo_q <= l_q) begin
					l_q    <= sl_q;
					r_q    <= sr_q;
					node_q <= sn_q;
				end else if (lo_q <= mid) begin
					r_q    <= mid;
					node_q <= child_l;
				end else begin
					l_q    <= mid_p1;
					node_q <= child_r;
				end
			end
			S_QRIGHT: begin
				if (!(r_q <= hi_q)) begin
					if (hi_q > mid) begin
						l_q    <= mid_p1;
						node_q <= child_r;
					end else begin
						r_q    <= mid;
						node_q <= child_l;
					end
				end
			end
			S_QDRAIN: begin
				res_val_q <= fold;
			end
			S_FINISH: begin
				if (out_free) begin
					out_val_q <= res_val_q;
					out_st_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-VAL_W){1'b0}}, out_val_q};
	assign m_axis_tuser  = out_st_q;

endmodule

FILE: design/rmst_checker.sv
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks of the range maximum segment tree, bound to the top.
// ----------------------------------------------------------------------------
module rmst_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [rmst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [rmst_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import rmst_pkg::*;

	// one request in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while previous one in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_UPD || m_axis_tuser == ST_QRY
			|| m_axis_tuser == ST_ERR))
		else $error("undefined status code");

	a_zero_unless_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_QRY) |-> (m_axis_tdata == '0))
		else $error("nonzero max_value on update or error beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat dropped or changed while stalled");

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);
